FILE: sv/sha_pkg.sv
// Package for the SHA-256 stream hasher: types, round constants, initial hash values
// and the round and schedule functions used by the core and the top level.
// No dependencies.
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_item_t;

  localparam int unsigned BlockLen = 64;
  localparam int unsigned LenPos   = 56;
  localparam logic [7:0]  PadMark  = 8'h80;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

FILE: sv/sha_stream_if.sv
// Valid/ready stream interface with a generic payload type.
// No dependencies; the payload type is a parameter.
interface sha_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: byte packing, padding sequencer and digest output.
// Depends on sha_pkg, sha_stream_if, sha_core.
//
//  channel   dir  payload
//  in_ch     in   data_byte[7:0], byte_present, message_end
//  out_ch    out  digest_word[31:0], word_last
//
// Each accepted byte passes through a wait state before the next is taken; a full block is
// compressed in sha_core (hash load, rounds, final add). An end adds one or two blocks,
// then 8 output words, then a reload of the initial hash. Reset loads the initial hash.
// Stalls on out_ch hold the digest readout.
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input logic clk,
  input logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_WAIT = 3'd1;
  localparam logic [2:0] T_PAD  = 3'd2;
  localparam logic [2:0] T_OUT  = 3'd3;
  localparam logic [2:0] T_RI   = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [31:0] wbuf;
  logic        fin;
  logic        len_done;
  logic [3:0]  oidx;
  logic        olive;
  logic        core_busy, start, load_we, reinit;
  logic [3:0]  load_addr;
  word_t       load_data, hdata;
  logic [7:0]  bval;
  logic        put;
  logic        in_ok;
  in_item_t    it;

  sha_core u_core (
    .clk(clk), .rst(rst), .load_we(load_we), .load_addr(load_addr),
    .load_data(load_data), .start(start), .reinit(reinit), .busy(core_busy),
    .hash_raddr(oidx[2:0]), .hash_rdata(hdata)
  );

  assign it    = in_ch.payload;
  assign in_ok = (state == T_IDLE) && !core_busy;
  assign in_ch.ready = in_ok;

  // at most one byte per cycle into the block, from input or from padding; both hold while the core is busy
  always_comb begin
    put  = 1'b0;
    bval = it.data_byte;
    if (in_ok && in_ch.valid && it.byte_present) begin
      put = 1'b1;
    end else if (state == T_PAD && !core_busy) begin
      put = 1'b1;
      if (!fin) bval = PadMark;
      else if (len_done) bval = bits[63 - 8*fill[2:0] -: 8];
      else bval = 8'h00;
    end
    load_we   = put && (fill[1:0] == 2'd3);
    load_addr = fill[5:2];
    load_data = {wbuf[23:0], bval};
    start     = load_we && (fill == 6'(BlockLen - 1));
    reinit    = (state == T_RI) && !core_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      fill  <= '0;
      bits  <= '0;
      fin   <= 1'b0;
      len_done <= 1'b0;
      oidx  <= '0;
      olive <= 1'b0;
    end else begin
      if (put) begin
        wbuf <= {wbuf[23:0], bval};
        fill <= fill + 6'd1;
      end
      unique case (state)
        T_IDLE: begin
          if (in_ch.valid && in_ok) begin
            if (it.byte_present) bits <= bits + 64'd8;
            state <= it.message_end ? T_PAD : T_WAIT;
          end
        end
        T_WAIT: state <= T_IDLE;
        T_PAD: begin
          if (!core_busy) begin
            fin <= 1'b1;
            if (fin && !len_done && fill == 6'(LenPos - 1)) len_done <= 1'b1;
            if (!fin && fill == 6'(LenPos - 1)) len_done <= 1'b1;
            if (len_done && fill == 6'(BlockLen - 1)) begin
              state <= T_OUT;
              oidx  <= '0;
            end
          end
        end
        T_OUT: begin
          if (!core_busy && !olive) begin
            olive <= 1'b1;
          end else if (olive && out_ch.ready) begin
            olive <= 1'b0;
            oidx  <= oidx + 4'd1;
            if (oidx == 4'd7) state <= T_RI;
          end
        end
        T_RI: begin
          if (!core_busy) begin
            state <= T_WAIT;
            bits <= '0; fin <= 1'b0; len_done <= 1'b0; fill <= '0;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid = olive;
  assign out_ch.payload.digest_word = hdata;
  assign out_ch.payload.word_last   = (oidx == 4'd7);

  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    core_busy |-> !in_ch.ready) else $error("input taken during compression");
  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> oidx < 4'd8) else $error("digest index out of range");
  a_pad_no_in: assert property (@(posedge clk) disable iff (rst)
    (state == T_PAD) |-> !in_ch.ready) else $error("input during padding");
endmodule

FILE: sv/sha_word_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module sha_word_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/sha_core.sv
// Compression core: eight working registers, hash state in a 8-deep memory,
// schedule window in a 16-deep memory read at one address per cycle. Uses sha_pkg.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // block load: sixteen words written before start
  input  logic        load_we,
  input  logic [3:0]  load_addr,
  input  word_t       load_data,
  input  logic        start,
  input  logic        reinit,
  output logic        busy,
  // hash readout
  input  logic [2:0]  hash_raddr,
  output word_t       hash_rdata
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_LDH   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;

  logic [2:0] state;
  logic [1:0] phase;
  logic [5:0] rnd;
  logic [3:0] hidx;
  logic [2:0] hprev;
  word_t a, b, c, d, e, f, g, h;
  word_t wt15, wsum, wp1, wp2, t1p;

  logic       w_we;
  logic [3:0] w_waddr, w_raddr;
  word_t      w_wdata, w_rdata;
  logic       h_we;
  logic [2:0] h_waddr, h_raddr;
  word_t      h_wdata, h_rdata;
  word_t      wr, t1, t2;
  word_t      vsel;

  sha_word_ram #(.Width(32), .Depth(16)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  sha_word_ram #(.Width(32), .Depth(8)) u_hram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign busy       = (state != S_IDLE);
  assign hash_rdata = h_rdata;
  assign hprev      = hidx[2:0] - 3'd1;

  always_comb begin
    wr = (rnd < 6'd16) ? w_rdata : (w_rdata + wsum);
    t1 = t1p + wr;
    t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
    unique case (hprev)
      3'd0: vsel = a;
      3'd1: vsel = b;
      3'd2: vsel = c;
      3'd3: vsel = d;
      3'd4: vsel = e;
      3'd5: vsel = f;
      3'd6: vsel = g;
      default: vsel = h;
    endcase
  end

  // schedule reads: phases 0..2 read w[r-15], w[r-7], w[r-16]; w[r-2] is held in wp2
  always_comb begin
    w_we    = load_we;
    w_waddr = load_addr;
    w_wdata = load_data;
    w_raddr = rnd[3:0];
    h_we    = 1'b0;
    h_waddr = hidx[2:0];
    h_wdata = InitHash[hidx[2:0]];
    h_raddr = hash_raddr;
    unique case (state)
      S_INIT: begin
        h_we = 1'b1;
      end
      S_LDH: begin
        h_raddr = hidx[2:0];
      end
      S_ROUND: begin
        unique case (phase)
          2'd0: w_raddr = rnd[3:0] - 4'd15;
          2'd1: w_raddr = rnd[3:0] - 4'd7;
          default: w_raddr = rnd[3:0];
        endcase
        if (phase == 2'd3 && rnd >= 6'd16) begin
          w_we    = 1'b1;
          w_waddr = rnd[3:0];
          w_wdata = wr;
        end
      end
      S_ADD: begin
        h_raddr = hidx[2:0];
        h_we    = hidx[3];
        h_waddr = hprev;
        h_wdata = h_rdata + vsel;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      hidx  <= '0;
      phase <= '0;
      rnd   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          hidx <= '0;
          if (reinit) begin
            state <= S_INIT;
          end else if (start) begin
            state <= S_LDH;
          end
        end
        S_INIT: begin
          hidx <= hidx + 4'd1;
          if (hidx[2:0] == 3'd7) begin
            state <= S_IDLE;
          end
        end
        S_LDH: begin
          // read issued at hidx, data valid next cycle for hidx-1
          hidx <= hidx + 4'd1;
          if (hidx != 4'd0) begin
            {a, b, c, d, e, f, g} <= {b, c, d, e, f, g, h};
            h <= h_rdata;
          end
          if (hidx == 4'd8) begin
            state <= S_ROUND;
            rnd   <= '0;
            phase <= '0;
          end
        end
        S_ROUND: begin
          phase <= phase + 2'd1;
          unique case (phase)
            2'd0: ;
            2'd1: wt15 <= w_rdata;
            2'd2: begin
              wsum <= sig0(wt15) + w_rdata + sig1(wp2);
              t1p  <= h + bsig1(e) + ((e & f) ^ (~e & g)) + RoundK[rnd];
            end
            default: begin
              h <= g; g <= f; f <= e; e <= d + t1;
              d <= c; c <= b; b <= a; a <= t1 + t2;
              wp2 <= wp1;
              wp1 <= wr;
              rnd <= rnd + 6'd1;
              if (rnd == 6'd63) begin
                state <= S_ADD;
                hidx  <= '0;
              end
            end
          endcase
        end
        S_ADD: begin
          hidx <= {1'b1, hidx[2:0] + 3'd1};
          if (hidx == 4'b1000) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
